@@ sv/assert_macros.svh @@
// assertion macros for the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is asserted
`define PFI_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion that also holds during reset
`define PFI_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ sv/pfi_pkg.sv @@
// shared constants, types and codes of the polyphase fir interpolator
// no dependencies
package pfi_pkg;

  localparam int TAPS       = 16;
  localparam int MAX_FACTOR = 8;

  localparam int KIND_W     = 2;
  localparam int SAMPLE_W   = 16;
  localparam int PHASE_W    = 3;
  localparam int TAP_W      = 4;
  localparam int COEF_W     = 18;
  localparam int FACTOR_W   = 4;

  localparam int TDATA_IN_W  = 48;
  localparam int TDATA_OUT_W = 16;

  localparam int HIST_AW    = $clog2(TAPS);
  localparam int PH_CW      = (MAX_FACTOR > 1) ? $clog2(MAX_FACTOR) : 1;
  localparam int FCNT_W     = $clog2(MAX_FACTOR + 1);
  localparam int COEF_DEPTH = MAX_FACTOR * TAPS;
  localparam int COEF_AW    = $clog2(COEF_DEPTH);

  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int ACC_W      = PROD_W + $clog2(TAPS);
  localparam int FRAC_SHIFT = 16;

  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_COEF   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_COEF,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_OUT
  } st_e;

  typedef struct packed {
    op_e                        op;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PH_CW-1:0]           phase;
    logic [HIST_AW-1:0]         tap;
    logic signed [COEF_W-1:0]   coef;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } qhead_t;

endpackage

@@ sv/pfi_front.sv @@
// front end: takes input beats, drops the ones that do nothing, queues the rest
// depends on pfi_pkg
module pfi_front (
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [pfi_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  input  logic [pfi_pkg::KIND_W-1:0]        s_axis_tuser_i,
  input  logic                              full_i,
  output logic                              push_o,
  output pfi_pkg::item_t                    item_o
);

  logic [pfi_pkg::PHASE_W-1:0] phase_in;
  logic [pfi_pkg::TAP_W-1:0]   tap_in;
  logic                        coef_in_range;
  logic                        keep;

  assign phase_in = s_axis_tdata_i[18:16];
  assign tap_in   = s_axis_tdata_i[22:19];

  assign coef_in_range = (32'(phase_in) < pfi_pkg::MAX_FACTOR) &&
                         (32'(tap_in) < pfi_pkg::TAPS);

  always_comb begin
    keep          = 1'b0;
    item_o.op     = pfi_pkg::OP_SAMPLE;
    item_o.sample = s_axis_tdata_i[15:0];
    item_o.phase  = pfi_pkg::PH_CW'(phase_in);
    item_o.tap    = pfi_pkg::HIST_AW'(tap_in);
    item_o.coef   = s_axis_tdata_i[40:23];
    case (s_axis_tuser_i)
      pfi_pkg::KIND_SAMPLE: begin
        keep      = 1'b1;
        item_o.op = pfi_pkg::OP_SAMPLE;
      end
      pfi_pkg::KIND_COEF: begin
        keep      = coef_in_range;
        item_o.op = pfi_pkg::OP_COEF;
      end
      pfi_pkg::KIND_CLEAR: begin
        keep      = 1'b1;
        item_o.op = pfi_pkg::OP_CLEAR;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // beats that change nothing are taken and dropped here
  assign s_axis_tready_o = !full_i;
  assign push_o          = s_axis_tvalid_i && !full_i && keep;

endmodule

@@ sv/pfi_queue.sv @@
// short item queue between the front end and the filter engine
// depends on pfi_pkg
module pfi_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  pfi_pkg::item_t   item_i,
  output logic             full_o,
  input  logic             pop_i,
  output pfi_pkg::qhead_t  head_o
);

  pfi_pkg::item_t             mem_q [pfi_pkg::QUEUE_DEPTH];
  logic [pfi_pkg::Q_AW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [pfi_pkg::Q_AW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [pfi_pkg::Q_CW-1:0]   count_q, count_d;
  logic                       do_pop;

  assign full_o       = (count_q == pfi_pkg::Q_CW'(pfi_pkg::QUEUE_DEPTH));
  assign head_o.valid = (count_q != '0);
  assign head_o.item  = mem_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pfi_pkg::Q_AW'(pfi_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + pfi_pkg::Q_AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == pfi_pkg::Q_AW'(pfi_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + pfi_pkg::Q_AW'(1);
    end
    case ({push_i, do_pop})
      2'b10:   count_d = count_q + pfi_pkg::Q_CW'(1);
      2'b01:   count_d = count_q - pfi_pkg::Q_CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

@@ sv/pfi_back.sv @@
// filter engine: history, coefficient memory, shared multiply-accumulate, output register
// depends on pfi_pkg
module pfi_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfi_pkg::qhead_t                    head_i,
  output logic                               pop_o,
  input  logic                               cfg_we_i,
  input  logic [pfi_pkg::FACTOR_W-1:0]       cfg_data_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  output logic [pfi_pkg::TDATA_OUT_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tlast_o
);

  localparam int SHR_W = pfi_pkg::ACC_W - pfi_pkg::FRAC_SHIFT;
  localparam logic signed [SHR_W-1:0] SAT_MAX = SHR_W'((1 << (pfi_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [SHR_W-1:0] SAT_MIN = -SHR_W'(1 << (pfi_pkg::SAMPLE_W - 1));
  localparam logic signed [pfi_pkg::ACC_W-1:0] ROUND_BIAS =
    pfi_pkg::ACC_W'(1 << (pfi_pkg::FRAC_SHIFT - 1));

  function automatic logic [pfi_pkg::FCNT_W-1:0] eff_factor(
    input logic [pfi_pkg::FACTOR_W-1:0] r
  );
    logic [pfi_pkg::FCNT_W-1:0] f;
    if (r == '0) begin
      f = pfi_pkg::FCNT_W'(1);
    end else if (32'(r) > pfi_pkg::MAX_FACTOR) begin
      f = pfi_pkg::FCNT_W'(pfi_pkg::MAX_FACTOR);
    end else begin
      f = pfi_pkg::FCNT_W'(r);
    end
    return f;
  endfunction

  pfi_pkg::st_e                        state_q, state_d;
  logic [pfi_pkg::FACTOR_W-1:0]        factor_q;
  logic signed [pfi_pkg::SAMPLE_W-1:0] hist_q [pfi_pkg::TAPS];
  logic [pfi_pkg::HIST_AW-1:0]         wpos_q, wpos_next;
  logic [pfi_pkg::PH_CW-1:0]           phase_q, phase_d;
  logic [pfi_pkg::HIST_AW-1:0]         tap_q, tap_d;

  logic signed [pfi_pkg::COEF_W-1:0]   coef_mem [pfi_pkg::COEF_DEPTH];
  logic [pfi_pkg::COEF_DEPTH-1:0]      coef_vld_q;

  logic                                s1_v_q, s2_v_q;
  logic signed [pfi_pkg::COEF_W-1:0]   coef_rd_q;
  logic                                coef_ok_q;
  logic signed [pfi_pkg::SAMPLE_W-1:0] hist_rd_q;
  logic signed [pfi_pkg::COEF_W-1:0]   coef_eff;
  logic signed [pfi_pkg::PROD_W-1:0]   prod_q;
  logic signed [pfi_pkg::ACC_W-1:0]    acc_q, acc_d;

  logic                                out_valid_q;
  logic [pfi_pkg::TDATA_OUT_W-1:0]     out_data_q;
  logic                                out_last_q;

  logic                                rd_en, hist_we, hist_clr, coef_we;
  logic                                acc_clr, out_load, wpos_adv, last_phase;
  logic                                out_free;
  logic [pfi_pkg::COEF_AW-1:0]         rd_addr, wr_addr;
  logic [pfi_pkg::HIST_AW-1:0]         hist_idx;
  logic signed [pfi_pkg::ACC_W-1:0]    rounded;
  logic signed [SHR_W-1:0]             shr;
  logic [pfi_pkg::TDATA_OUT_W-1:0]     sat;

  assign out_free   = !out_valid_q || m_axis_tready_i;
  assign last_phase = (pfi_pkg::FCNT_W'(phase_q) ==
                       eff_factor(factor_q) - pfi_pkg::FCNT_W'(1));

  assign rd_addr = pfi_pkg::COEF_AW'(phase_q) * pfi_pkg::COEF_AW'(pfi_pkg::TAPS) +
                   pfi_pkg::COEF_AW'(tap_q);
  assign wr_addr = pfi_pkg::COEF_AW'(head_i.item.phase) * pfi_pkg::COEF_AW'(pfi_pkg::TAPS) +
                   pfi_pkg::COEF_AW'(head_i.item.tap);

  // newest first: tap t pairs with the sample written t steps earlier
  assign hist_idx = (tap_q <= wpos_q) ? wpos_q - tap_q :
                    wpos_q + pfi_pkg::HIST_AW'(pfi_pkg::TAPS) - tap_q;

  assign wpos_next = (wpos_q == pfi_pkg::HIST_AW'(pfi_pkg::TAPS - 1)) ? '0 :
                     wpos_q + pfi_pkg::HIST_AW'(1);

  // round half up then saturate to the sample range
  assign rounded = acc_q + ROUND_BIAS;
  assign shr     = rounded[pfi_pkg::ACC_W-1:pfi_pkg::FRAC_SHIFT];
  always_comb begin
    if (shr > SAT_MAX) begin
      sat = SAT_MAX[pfi_pkg::TDATA_OUT_W-1:0];
    end else if (shr < SAT_MIN) begin
      sat = SAT_MIN[pfi_pkg::TDATA_OUT_W-1:0];
    end else begin
      sat = shr[pfi_pkg::TDATA_OUT_W-1:0];
    end
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    tap_d    = tap_q;
    pop_o    = 1'b0;
    rd_en    = 1'b0;
    hist_we  = 1'b0;
    hist_clr = 1'b0;
    coef_we  = 1'b0;
    acc_clr  = 1'b0;
    out_load = 1'b0;
    wpos_adv = 1'b0;
    case (state_q)
      pfi_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.item.op)
            pfi_pkg::OP_SAMPLE: begin
              hist_we = 1'b1;
              phase_d = '0;
              tap_d   = '0;
              acc_clr = 1'b1;
              state_d = pfi_pkg::ST_RUN;
            end
            pfi_pkg::OP_COEF: begin
              coef_we = 1'b1;
            end
            pfi_pkg::OP_CLEAR: begin
              hist_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      pfi_pkg::ST_RUN: begin
        rd_en = 1'b1;
        if (tap_q == pfi_pkg::HIST_AW'(pfi_pkg::TAPS - 1)) begin
          state_d = pfi_pkg::ST_DRAIN;
        end else begin
          tap_d = tap_q + pfi_pkg::HIST_AW'(1);
        end
      end
      pfi_pkg::ST_DRAIN: begin
        if (!s1_v_q && !s2_v_q) begin
          state_d = pfi_pkg::ST_OUT;
        end
      end
      pfi_pkg::ST_OUT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (last_phase) begin
            wpos_adv = 1'b1;
            state_d  = pfi_pkg::ST_IDLE;
          end else begin
            phase_d = phase_q + pfi_pkg::PH_CW'(1);
            tap_d   = '0;
            acc_clr = 1'b1;
            state_d = pfi_pkg::ST_RUN;
          end
        end
      end
      default: begin
        state_d = pfi_pkg::ST_IDLE;
      end
    endcase
  end

  assign coef_eff = coef_ok_q ? coef_rd_q : '0;

  always_comb begin
    if (acc_clr) begin
      acc_d = '0;
    end else if (s2_v_q) begin
      acc_d = acc_q + pfi_pkg::ACC_W'(prod_q);
    end else begin
      acc_d = acc_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pfi_pkg::ST_IDLE;
      factor_q    <= pfi_pkg::FACTOR_W'(1);
      wpos_q      <= '0;
      phase_q     <= '0;
      tap_q       <= '0;
      s1_v_q      <= 1'b0;
      s2_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
      coef_vld_q  <= '0;
      for (int i = 0; i < pfi_pkg::TAPS; i++) begin
        hist_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      tap_q   <= tap_d;
      s1_v_q  <= rd_en;
      s2_v_q  <= s1_v_q;
      if (cfg_we_i) begin
        factor_q <= cfg_data_i;
      end
      if (coef_we) begin
        coef_vld_q[wr_addr] <= 1'b1;
      end
      if (hist_clr) begin
        wpos_q <= '0;
        for (int i = 0; i < pfi_pkg::TAPS; i++) begin
          hist_q[i] <= '0;
        end
      end else begin
        if (hist_we) begin
          hist_q[wpos_q] <= head_i.item.sample;
        end
        if (wpos_adv) begin
          wpos_q <= wpos_next;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // coefficient memory, registered read
  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[wr_addr] <= head_i.item.coef;
    end
    if (rd_en) begin
      coef_rd_q <= coef_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      coef_ok_q <= coef_vld_q[rd_addr];
      hist_rd_q <= hist_q[hist_idx];
    end
    if (s1_v_q) begin
      prod_q <= coef_eff * hist_rd_q;
    end
    acc_q <= acc_d;
    if (out_load) begin
      out_data_q <= sat;
      out_last_q <= last_phase;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

@@ sv/polyphase_fir_interpolator_core.sv @@
// Polyphase FIR interpolator, fixed point (Q1.15 samples, Q2.16 coefficients). Each sample
// beat yields F output beats (F = interp_factor clamped to 1..8), the last one with tlast.
// A single shared multiply-accumulate walks the taps of one phase at a time. A two-entry
// queue lets the input side keep taking beats while the engine works and the output
// register waits on the sink. The coefficient memory reads as zero until written, so no
// clearing pass runs after reset.
// depends on pfi_pkg, pfi_front, pfi_queue, pfi_back
module polyphase_fir_interpolator_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // tdata: sample_in[15:0], coef_phase[18:16], coef_tap[22:19], coef_value[40:23], zero[47:41]
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [pfi_pkg::TDATA_IN_W-1:0]    s_axis_tdata_i,
  // tuser: kind[1:0]
  input  logic [pfi_pkg::KIND_W-1:0]        s_axis_tuser_i,
  // tdata: sample_out[15:0]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [pfi_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  output logic                              m_axis_tlast_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pfi_pkg::FACTOR_W-1:0]      cfg_data_i
);

  logic            q_full;
  logic            q_push;
  logic            q_pop;
  pfi_pkg::item_t  q_item;
  pfi_pkg::qhead_t q_head;

  assign cfg_ready_o = 1'b1;

  pfi_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .full_i          (q_full),
    .push_o          (q_push),
    .item_o          (q_item)
  );

  pfi_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .item_i (q_item),
    .full_o (q_full),
    .pop_i  (q_pop),
    .head_o (q_head)
  );

  pfi_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (q_head),
    .pop_o           (q_pop),
    .cfg_we_i        (cfg_valid_i),
    .cfg_data_i      (cfg_data_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

@@ sv/pfi_checker.sv @@
// port-level checks of the interpolator, attached by bind
// depends on pfi_pkg, assert_macros.svh, polyphase_fir_interpolator_core
`include "assert_macros.svh"

module pfi_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid_o,
  input logic                              m_axis_tready_i,
  input logic [pfi_pkg::TDATA_OUT_W-1:0]   m_axis_tdata_o,
  input logic                              m_axis_tlast_o,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o
);

  localparam int CNT_W = $clog2(pfi_pkg::MAX_FACTOR + 1);

  logic [CNT_W-1:0] beat_cnt_q;

  // output beats since the last tlast beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_cnt_q <= '0;
    end else if (m_axis_tvalid_o && m_axis_tready_i) begin
      beat_cnt_q <= m_axis_tlast_o ? '0 : beat_cnt_q + CNT_W'(1);
    end
  end

  `PFI_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output beat changed while stalled")
  `PFI_ASSERT_NR(a_rst_quiet, clk_i, !rst_ni |-> !m_axis_tvalid_o, "output valid during reset")
  `PFI_ASSERT(a_run_len, clk_i, rst_ni, m_axis_tvalid_o && (beat_cnt_q == CNT_W'(pfi_pkg::MAX_FACTOR - 1)) |-> m_axis_tlast_o, "run longer than the largest factor")
  `PFI_ASSERT(a_cfg_ready, clk_i, rst_ni, cfg_valid_i |-> cfg_ready_o, "register write refused")

endmodule

bind polyphase_fir_interpolator_core pfi_checker u_pfi_checker (.*);

@@ sim/polyphase_fir_interpolator_core_tb.sv @@
// self-checking testbench for polyphase_fir_interpolator_core: a scoreboard class predicts
// every output beat from sample, coefficient and clear beats; depends on pfi_pkg and the core
`timescale 1ns / 1ps

typedef struct {
  logic signed [pfi_pkg::SAMPLE_W-1:0] value;
  logic                                last;
} fir_out_beat_t;

class fir_scoreboard;
  logic signed [pfi_pkg::SAMPLE_W-1:0] history [pfi_pkg::TAPS];
  int                                  wr_pos;
  logic signed [pfi_pkg::COEF_W-1:0]   coefs [pfi_pkg::COEF_DEPTH];
  logic [pfi_pkg::FACTOR_W-1:0]        factor;
  fir_out_beat_t                       pending_beats [$];
  int                                  fails;

  function new();
    foreach (history[i]) history[i] = '0;
    foreach (coefs[i]) coefs[i] = '0;
    wr_pos = 0;
    factor = 4'd1;
    fails  = 0;
  endfunction

  function void set_factor(logic [pfi_pkg::FACTOR_W-1:0] f);
    factor = f;
  endfunction

  // accepted input beat: update state and queue the outputs a sample produces
  function void note_input(logic [pfi_pkg::KIND_W-1:0] kind,
                           logic [pfi_pkg::TDATA_IN_W-1:0] data);
    logic signed [pfi_pkg::SAMPLE_W-1:0] smp;
    logic [pfi_pkg::PHASE_W-1:0]         ph;
    logic [pfi_pkg::TAP_W-1:0]           tp;
    logic signed [pfi_pkg::COEF_W-1:0]   cf;
    int                                  nphase;
    int                                  h;
    longint                              acc;
    longint                              r;
    fir_out_beat_t                       beat;
    smp = data[15:0];
    ph  = data[18:16];
    tp  = data[22:19];
    cf  = data[40:23];
    case (kind)
      pfi_pkg::KIND_COEF: begin
        if (ph < pfi_pkg::MAX_FACTOR && tp < pfi_pkg::TAPS)
          coefs[ph * pfi_pkg::TAPS + tp] = cf;
      end
      pfi_pkg::KIND_CLEAR: begin
        foreach (history[i]) history[i] = '0;
        wr_pos = 0;
      end
      pfi_pkg::KIND_SAMPLE: begin
        nphase = (factor == 0) ? 1 :
                 ((factor > pfi_pkg::MAX_FACTOR) ? pfi_pkg::MAX_FACTOR : factor);
        history[wr_pos] = smp;
        for (int p = 0; p < nphase; p++) begin
          acc = 0;
          h = wr_pos;
          // newest sample pairs with tap 0
          for (int j = 0; j < pfi_pkg::TAPS; j++) begin
            acc += longint'(coefs[p * pfi_pkg::TAPS + j]) * longint'(history[h]);
            h = (h == 0) ? pfi_pkg::TAPS - 1 : h - 1;
          end
          r = (acc + 64'sd32768) >>> pfi_pkg::FRAC_SHIFT;
          if (r > 32767) r = 32767;
          if (r < -32768) r = -32768;
          beat.value = r[pfi_pkg::SAMPLE_W-1:0];
          beat.last  = (p == nphase - 1);
          pending_beats = {pending_beats, beat};
        end
        wr_pos = (wr_pos + 1) % pfi_pkg::TAPS;
      end
      default: ;
    endcase
  endfunction

  function void check_output(logic [pfi_pkg::TDATA_OUT_W-1:0] data, logic last);
    fir_out_beat_t want;
    if (pending_beats.size() == 0) begin
      fails++;
      $display("%0t: unexpected output beat, actual sample_out %0d last %b",
               $time, $signed(data[pfi_pkg::SAMPLE_W-1:0]), last);
      return;
    end
    want = pending_beats.pop_front();
    if (data[pfi_pkg::SAMPLE_W-1:0] !== want.value) begin
      fails++;
      $display("%0t: sample_out mismatch, expected %0d actual %0d",
               $time, want.value, $signed(data[pfi_pkg::SAMPLE_W-1:0]));
    end
    if (last !== want.last) begin
      fails++;
      $display("%0t: last_phase mismatch, expected %b actual %b", $time, want.last, last);
    end
  endfunction
endclass

module polyphase_fir_interpolator_core_tb;

  localparam logic [pfi_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int SETTLE_WAIT  = 100;
  localparam int BEATS_PER_SETTING = 38;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             s_axis_tvalid_i;
  logic                             s_axis_tready_o;
  logic [pfi_pkg::TDATA_IN_W-1:0]   s_axis_tdata_i;
  logic [pfi_pkg::KIND_W-1:0]       s_axis_tuser_i;
  logic                             m_axis_tvalid_o;
  logic                             m_axis_tready_i;
  logic [pfi_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o;
  logic                             m_axis_tlast_o;
  logic                             cfg_valid_i;
  logic                             cfg_ready_o;
  logic [pfi_pkg::FACTOR_W-1:0]     cfg_data_i;

  fir_scoreboard board;
  int src_gap_pct;
  int sink_stall_pct;
  int cycle_count;
  logic [pfi_pkg::FACTOR_W-1:0] factor_plan [6] = '{4'd8, 4'd3, 4'd15, 4'd0, 4'd5, 4'd2};

  polyphase_fir_interpolator_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // sink side: check accepted beats, then pick next ready at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      board.check_output(m_axis_tdata_o, m_axis_tlast_o);
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  function automatic logic [pfi_pkg::TDATA_IN_W-1:0] pack_fields(
    logic [pfi_pkg::SAMPLE_W-1:0] smp,
    logic [pfi_pkg::PHASE_W-1:0]  ph,
    logic [pfi_pkg::TAP_W-1:0]    tp,
    logic [pfi_pkg::COEF_W-1:0]   cf
  );
    return {7'd0, cf, tp, ph, smp};
  endfunction

  task automatic send_beat(input logic [pfi_pkg::KIND_W-1:0] kind,
                           input logic [pfi_pkg::TDATA_IN_W-1:0] data);
    while ($urandom_range(99) < src_gap_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= data;
    s_axis_tuser_i  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    board.note_input(kind, data);
  endtask

  task automatic send_sample(input logic [pfi_pkg::SAMPLE_W-1:0] smp);
    send_beat(pfi_pkg::KIND_SAMPLE, pack_fields(smp, '0, '0, '0));
  endtask

  task automatic send_coef(input int ph, input int tp, input int cf);
    send_beat(pfi_pkg::KIND_COEF,
              pack_fields('0, ph[pfi_pkg::PHASE_W-1:0], tp[pfi_pkg::TAP_W-1:0],
                          cf[pfi_pkg::COEF_W-1:0]));
  endtask

  // coefficient and clear beats leave no trace at the output, so settle a while
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    while (board.pending_beats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_factor(input logic [pfi_pkg::FACTOR_W-1:0] f);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= f;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    board.set_factor(f);
  endtask

  task automatic send_random_beat(output bit counted);
    logic [pfi_pkg::KIND_W-1:0] kind;
    logic [pfi_pkg::COEF_W-1:0] cf;
    int pick;
    pick = $urandom_range(99);
    if (pick < 62) kind = pfi_pkg::KIND_SAMPLE;
    else if (pick < 88) kind = pfi_pkg::KIND_COEF;
    else if (pick < 94) kind = pfi_pkg::KIND_CLEAR;
    else kind = KIND_UNUSED;
    // mostly modest coefficients so the sums do not always saturate
    if ($urandom_range(3) == 0) cf = pfi_pkg::COEF_W'($urandom);
    else cf = pfi_pkg::COEF_W'($urandom_range(8191) - 4096);
    send_beat(kind, pack_fields(pfi_pkg::SAMPLE_W'($urandom), pfi_pkg::PHASE_W'($urandom),
                                pfi_pkg::TAP_W'($urandom), cf));
    counted = (kind != KIND_UNUSED);
  endtask

  initial begin
    bit counted;
    int sent;
    board = new();
    rst_ni          <= 1'b0;
    s_axis_tvalid_i <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tuser_i  <= pfi_pkg::KIND_SAMPLE;
    cfg_valid_i     <= 1'b0;
    cfg_data_i      <= '0;
    m_axis_tready_i <= 1'b0;
    cycle_count     <= 0;
    src_gap_pct     = 16;
    sink_stall_pct  = 62;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset factor of one and an all-zero coefficient memory
    send_sample(16'h7fff);
    send_coef(0, 0, 131071);
    send_coef(0, 1, -131072);
    send_coef(7, 15, -1);
    send_coef(3, 8, 65536);
    send_coef(1, 0, 1);
    send_beat(KIND_UNUSED, '1);
    send_sample(16'h7fff);
    send_sample(16'h8000);
    send_sample(16'h0000);
    send_beat(pfi_pkg::KIND_CLEAR, '0);
    send_sample(16'h8000);
    send_sample(16'h7fff);
    wait_drained();
    write_factor(4'd8);
    send_sample(16'h7fff);
    send_sample(16'hffff);
    send_sample(16'h0001);
    send_sample(16'h8000);
    wait_drained();
    // zero and oversized factors clamp
    write_factor(4'd0);
    send_sample(16'h3039);
    send_sample(16'h8001);
    wait_drained();
    write_factor(4'd15);
    send_sample(16'h8000);
    send_beat(pfi_pkg::KIND_CLEAR, '0);
    send_sample(16'h4000);
    wait_drained();

    foreach (factor_plan[s]) begin
      case (s / 2)
        0: begin
          src_gap_pct    = 16;
          sink_stall_pct = 62;
        end
        1: begin
          src_gap_pct    = 62;
          sink_stall_pct = 16;
        end
        default: begin
          src_gap_pct    = 0;
          sink_stall_pct = 0;
        end
      endcase
      write_factor(factor_plan[s]);
      sent = 0;
      while (sent < BEATS_PER_SETTING) begin
        send_random_beat(counted);
        if (counted) sent++;
      end
      wait_drained();
    end

    if (board.fails == 0 && board.pending_beats.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
